### rtl/msc_pkg.sv
package msc_pkg;

    localparam int MAX_WIDTH_DEF = 4096;
    localparam int FRAC_BITS_DEF = 16;
    localparam int MAX_HEIGHT    = 4096;
    localparam int ROW_W         = 12;
    localparam int PIX_W         = 16;
    localparam int COORD_W       = 28;
    localparam int CFG_IDX_W     = 8;
    localparam int CFG_DATA_W    = 16;
    localparam int DIM_W         = 13;

    localparam logic [CFG_IDX_W-1:0] REG_LEVEL   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONNECT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 8'd3;

    localparam logic [1:0] EDGE_T = 2'd0;
    localparam logic [1:0] EDGE_B = 2'd1;
    localparam logic [1:0] EDGE_L = 2'd2;
    localparam logic [1:0] EDGE_R = 2'd3;

    // request to the edge divider
    typedef struct packed {
        logic        start;
        logic        zero;
        logic [16:0] num;
        logic [16:0] den;
    } div_req_t;

    function automatic logic [1:0] seg_count(input logic [3:0] code);
        logic [1:0] n;
        case (code)
            4'd0, 4'd15: n = 2'd0;
            4'd6, 4'd9:  n = 2'd2;
            default:     n = 2'd1;
        endcase
        return n;
    endfunction

    // {start0, end0, start1, end1}
    function automatic logic [7:0] seg_pairs(input logic [3:0] code, input logic high);
        logic [7:0] p;
        case (code)
            4'd1:    p = {EDGE_T, EDGE_L, EDGE_T, EDGE_T};
            4'd2:    p = {EDGE_R, EDGE_T, EDGE_T, EDGE_T};
            4'd3:    p = {EDGE_R, EDGE_L, EDGE_T, EDGE_T};
            4'd4:    p = {EDGE_L, EDGE_B, EDGE_T, EDGE_T};
            4'd5:    p = {EDGE_T, EDGE_B, EDGE_T, EDGE_T};
            4'd6:    p = high ? {EDGE_L, EDGE_T, EDGE_R, EDGE_B}
                          : {EDGE_R, EDGE_T, EDGE_L, EDGE_B};
            4'd7:    p = {EDGE_R, EDGE_B, EDGE_T, EDGE_T};
            4'd8:    p = {EDGE_B, EDGE_R, EDGE_T, EDGE_T};
            4'd9:    p = high ? {EDGE_T, EDGE_R, EDGE_B, EDGE_L}
                          : {EDGE_T, EDGE_L, EDGE_B, EDGE_R};
            4'd10:   p = {EDGE_B, EDGE_T, EDGE_T, EDGE_T};
            4'd11:   p = {EDGE_B, EDGE_L, EDGE_T, EDGE_T};
            4'd12:   p = {EDGE_L, EDGE_R, EDGE_T, EDGE_T};
            4'd13:   p = {EDGE_T, EDGE_R, EDGE_T, EDGE_T};
            4'd14:   p = {EDGE_L, EDGE_T, EDGE_T, EDGE_T};
            default: p = 8'd0;
        endcase
        return p;
    endfunction

endpackage

### rtl/marching_squares_contour.sv
// marching squares contour tracer, one signed sample per item in raster order
// a pixel with a segment waits while the bit-serial edge divider, shared by
//   the edges of the square, runs for each edge in turn
// one pixel at a time: the next is taken only after the last segment of this one
//   has been accepted, and output stalls hold it further
// reset: synchronous active-low, clears position, corner samples and state, sets config
//   to defaults; the line buffer is not cleared and is filled by the first image row
module marching_squares_contour #(
    parameter int MAX_WIDTH = msc_pkg::MAX_WIDTH_DEF,
    parameter int FRAC_BITS = msc_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [msc_pkg::PIX_W-1:0]     s_pixel_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [msc_pkg::COORD_W-1:0]          m_start_row,
    output logic [msc_pkg::COORD_W-1:0]          m_start_col,
    output logic [msc_pkg::COORD_W-1:0]          m_end_row,
    output logic [msc_pkg::COORD_W-1:0]          m_end_col,
    output logic                                 m_last_of_pixel,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [msc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [msc_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = msc_pkg::ROW_W;
    localparam int PW    = msc_pkg::PIX_W;
    localparam int COORD = msc_pkg::COORD_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLASS = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_WAIT  = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    // configuration registers
    logic signed [PW-1:0]          level_reg;
    logic                          connect_reg;
    logic [msc_pkg::DIM_W-1:0]     width_reg;
    logic [msc_pkg::DIM_W-1:0]     height_reg;

    // scan position and corner samples
    logic [CW-1:0]          col_reg;
    logic [RW-1:0]          row_reg;
    logic signed [PW-1:0]   left_reg;
    logic signed [PW-1:0]   ul_reg;

    // item under work
    logic [2:0]             state_reg;
    logic signed [PW-1:0]   px_reg;
    logic [CW-1:0]          cadj_reg;
    logic [RW-1:0]          radj_reg;
    logic                   square_reg;
    logic signed [PW-1:0]   c_ul_reg, c_ur_reg, c_ll_reg, c_lr_reg;
    logic [1:0]             count_reg;
    logic [7:0]             pairs_reg;
    logic [1:0]             edge_reg;
    logic                   seg_reg;
    logic [FRAC_BITS:0]     frac_reg [4];

    // effective sizes, clamped
    logic [31:0]            w32, h32;
    logic [CW:0]            weff;
    logic [msc_pkg::DIM_W-1:0] heff;

    always_comb begin
        w32 = 32'(width_reg);
        if (w32 < 32'd2) w32 = 32'd2;
        if (w32 > 32'(MAX_WIDTH)) w32 = 32'(MAX_WIDTH);
        h32 = 32'(height_reg);
        if (h32 < 32'd2) h32 = 32'd2;
        if (h32 > 32'(msc_pkg::MAX_HEIGHT)) h32 = 32'(msc_pkg::MAX_HEIGHT);
        weff = w32[CW:0];
        heff = h32[msc_pkg::DIM_W-1:0];
    end

    // position of the arriving pixel, after wrapping a shrunk frame
    logic                       pre_wrap;
    logic [CW-1:0]              col_adj;
    logic [msc_pkg::DIM_W-1:0]  row_t;
    logic [RW-1:0]              row_adj;

    always_comb begin
        pre_wrap = {1'b0, col_reg} >= weff;
        col_adj  = pre_wrap ? '0 : col_reg;
        row_t    = pre_wrap ? ({1'b0, row_reg} + 13'd1) : {1'b0, row_reg};
        row_adj  = (row_t >= heff) ? '0 : row_t[RW-1:0];
    end

    logic accept;
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // line buffer: read above sample on accept, write the new one in the following cycle (ST_CLASS)
    logic [PW-1:0] up_data;

    msc_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .aclk  (aclk),
        .we    (state_reg == ST_CLASS),
        .waddr (cadj_reg),
        .wdata (px_reg),
        .re    (accept),
        .raddr (col_adj),
        .rdata (up_data)
    );

    // square classification from the fresh corners
    logic signed [PW-1:0] up_s;
    logic [3:0]           code;
    assign up_s = up_data;
    always_comb begin
        code[0] = ul_reg   > level_reg;
        code[1] = up_s     > level_reg;
        code[2] = left_reg > level_reg;
        code[3] = px_reg   > level_reg;
    end

    // advance of the scan position
    logic [CW:0]               col1;
    logic [msc_pkg::DIM_W-1:0] row1;
    assign col1 = {1'b0, cadj_reg} + (CW+1)'(1);
    assign row1 = {1'b0, radj_reg} + 13'd1;

    // edge operands for the divider
    logic signed [PW-1:0] ea, eb;
    logic signed [17:0]   en, ed;
    msc_pkg::div_req_t    dreq;
    logic                 ddone;
    logic [FRAC_BITS:0]   dquot;

    always_comb begin
        case (edge_reg)
            msc_pkg::EDGE_T: begin ea = c_ul_reg; eb = c_ur_reg; end
            msc_pkg::EDGE_B: begin ea = c_ll_reg; eb = c_lr_reg; end
            msc_pkg::EDGE_L: begin ea = c_ul_reg; eb = c_ll_reg; end
            default:         begin ea = c_ur_reg; eb = c_lr_reg; end
        endcase
        if (ea > level_reg) begin
            en = 18'(ea) - 18'(level_reg);
            ed = 18'(ea) - 18'(eb);
        end else begin
            en = 18'(level_reg) - 18'(ea);
            ed = 18'(eb) - 18'(ea);
        end
        dreq.start = (state_reg == ST_START);
        // no crossing on this edge gives a zero fraction
        dreq.zero  = (ed <= 18'sd0) || (en < 18'sd0) || (en > ed);
        dreq.num   = en[16:0];
        dreq.den   = ed[16:0];
    end

    msc_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .done    (ddone),
        .quot    (dquot)
    );

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            col_reg     <= '0;
            row_reg     <= '0;
            left_reg    <= '0;
            ul_reg      <= '0;
            level_reg   <= '0;
            connect_reg <= 1'b0;
            width_reg   <= 13'd4096;
            height_reg  <= 13'd4096;
            edge_reg    <= '0;
            seg_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    msc_pkg::REG_LEVEL:   level_reg   <= cfg_data;
                    msc_pkg::REG_CONNECT: connect_reg <= cfg_data[0];
                    msc_pkg::REG_WIDTH:   width_reg   <= cfg_data[msc_pkg::DIM_W-1:0];
                    msc_pkg::REG_HEIGHT:  height_reg  <= cfg_data[msc_pkg::DIM_W-1:0];
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_CLASS;
                    end
                end
                ST_CLASS: begin
                    ul_reg   <= up_s;
                    left_reg <= px_reg;
                    if (col1 >= weff) begin
                        col_reg <= '0;
                        row_reg <= (row1 >= heff) ? '0 : row1[RW-1:0];
                    end else begin
                        col_reg <= col1[CW-1:0];
                        row_reg <= radj_reg;
                    end
                    edge_reg <= '0;
                    seg_reg  <= 1'b0;
                    if (square_reg && (msc_pkg::seg_count(code) != 2'd0)) begin
                        state_reg <= ST_START;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_START: begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (ddone) begin
                        if (edge_reg == msc_pkg::EDGE_R) begin
                            state_reg <= ST_OUT;
                        end else begin
                            edge_reg  <= edge_reg + 2'd1;
                            state_reg <= ST_START;
                        end
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        if (m_last_of_pixel) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            seg_reg <= 1'b1;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // payload of the item under work
    always_ff @(posedge aclk) begin
        if (accept) begin
            px_reg     <= s_pixel_value;
            cadj_reg   <= col_adj;
            radj_reg   <= row_adj;
            square_reg <= (row_adj != '0) && (col_adj != '0);
        end
        if (state_reg == ST_CLASS) begin
            c_ul_reg  <= ul_reg;
            c_ur_reg  <= up_s;
            c_ll_reg  <= left_reg;
            c_lr_reg  <= px_reg;
            count_reg <= msc_pkg::seg_count(code);
            pairs_reg <= msc_pkg::seg_pairs(code, connect_reg);
        end
        if ((state_reg == ST_WAIT) && ddone) begin
            frac_reg[edge_reg] <= dquot;
        end
    end

    // endpoint coordinates of each edge of the square
    logic [63:0] rb, cb, one;
    logic [63:0] erow [4];
    logic [63:0] ecol [4];

    always_comb begin
        rb  = 64'(radj_reg - RW'(1)) << FRAC_BITS;
        cb  = 64'(cadj_reg - CW'(1)) << FRAC_BITS;
        one = 64'(1) << FRAC_BITS;
        erow[msc_pkg::EDGE_T] = rb;
        ecol[msc_pkg::EDGE_T] = cb + 64'(frac_reg[msc_pkg::EDGE_T]);
        erow[msc_pkg::EDGE_B] = rb + one;
        ecol[msc_pkg::EDGE_B] = cb + 64'(frac_reg[msc_pkg::EDGE_B]);
        erow[msc_pkg::EDGE_L] = rb + 64'(frac_reg[msc_pkg::EDGE_L]);
        ecol[msc_pkg::EDGE_L] = cb;
        erow[msc_pkg::EDGE_R] = rb + 64'(frac_reg[msc_pkg::EDGE_R]);
        ecol[msc_pkg::EDGE_R] = cb + one;
    end

    logic [1:0] s_edge, e_edge;
    assign s_edge = seg_reg ? pairs_reg[3:2] : pairs_reg[7:6];
    assign e_edge = seg_reg ? pairs_reg[1:0] : pairs_reg[5:4];

    assign m_valid         = (state_reg == ST_OUT);
    assign m_start_row     = erow[s_edge][COORD-1:0];
    assign m_start_col     = ecol[s_edge][COORD-1:0];
    assign m_end_row       = erow[e_edge][COORD-1:0];
    assign m_end_col       = ecol[e_edge][COORD-1:0];
    // second segment, or the only one
    assign m_last_of_pixel = seg_reg || (count_reg == 2'd1);

endmodule

### rtl/msc_ram.sv
module msc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/msc_div.sv
module msc_div #(
    parameter int FRAC_BITS = msc_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  msc_pkg::div_req_t  req,
    output logic               done,
    output logic [FRAC_BITS:0] quot
);

    localparam int STEPS = FRAC_BITS + 1;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [17:0]          rem_reg,  rem_next;
    logic [16:0]          den_reg;
    logic [FRAC_BITS:0]   q_reg,    q_next;
    logic [CNT_W-1:0]     cnt_reg,  cnt_next;
    logic                 zero_reg;
    logic                 done_reg, done_next;
    logic                 ge;
    logic [17:0]          diff;

    // restoring division, one quotient bit a cycle, msb first
    always_comb begin
        ge        = rem_reg >= {1'b0, den_reg};
        diff      = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;
        rem_next  = {diff[16:0], 1'b0};
        q_next    = {q_reg[FRAC_BITS-1:0], ge};
        cnt_next  = cnt_reg - CNT_W'(1);
        done_next = (cnt_reg == CNT_W'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (req.start) begin
            cnt_reg  <= CNT_W'(STEPS);
            done_reg <= 1'b0;
        end else if (cnt_reg != '0) begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg  <= {1'b0, req.num};
            den_reg  <= req.den;
            q_reg    <= '0;
            zero_reg <= req.zero;
        end else if (cnt_reg != '0) begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign done = done_reg;
    assign quot = zero_reg ? '0 : q_reg;

endmodule

### bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import msc_pkg::*;

    typedef struct {
        logic [COORD_W-1:0] start_row;
        logic [COORD_W-1:0] start_col;
        logic [COORD_W-1:0] end_row;
        logic [COORD_W-1:0] end_col;
        logic               last_of_pixel;
    } segment_t;

    // predicts the contour segments of each accepted pixel and checks the outputs
    class contour_scoreboard;
        logic [PIX_W-1:0] line_buf [MAX_WIDTH_DEF];
        logic [PIX_W-1:0] left_px;
        logic [PIX_W-1:0] upleft_px;
        int               col;
        int               row;
        logic [PIX_W-1:0] level;
        logic             join_high;
        logic [DIM_W-1:0] width_reg;
        logic [DIM_W-1:0] height_reg;
        segment_t         expected_segments [$];
        int               mismatches;

        function new();
            foreach (line_buf[i]) line_buf[i] = '0;
            left_px = '0;
            upleft_px = '0;
            col = 0;
            row = 0;
            level = '0;
            join_high = 1'b0;
            width_reg = 13'd4096;
            height_reg = 13'd4096;
            mismatches = 0;
        endfunction

        function int eff_width();
            return (width_reg < 2) ? 2 : (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF
                                                                     : int'(width_reg);
        endfunction

        function int eff_height();
            return (height_reg < 2) ? 2 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT
                                                                   : int'(height_reg);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_LEVEL:   level = data;
                REG_CONNECT: join_high = data[0];
                REG_WIDTH:   width_reg = data[DIM_W-1:0];
                REG_HEIGHT:  height_reg = data[DIM_W-1:0];
                default: ;
            endcase
        endfunction

        // pixels still needed to bring the raster position back to the frame origin
        function int pixels_to_frame_end();
            int c, r, w, h;
            w = eff_width();
            h = eff_height();
            c = col;
            r = row;
            if (c >= w) begin
                c = 0;
                r++;
            end
            if (r >= h) r = 0;
            if (c == 0 && r == 0) return 0;
            return (h - r) * w - c;
        endfunction

        function longint crossing(int a, int b, int lvl);
            int n, d;
            if (a > lvl) begin
                n = a - lvl;
                d = a - b;
            end else begin
                n = lvl - a;
                d = b - a;
            end
            if (d <= 0 || n < 0 || n > d) return 0;
            return (longint'(n) << FRAC_BITS_DEF) / longint'(d);
        endfunction

        function void edge_point(logic [1:0] e, int r0, int c0, int ul, int ur, int ll,
                                 int lr, int lvl, output logic [COORD_W-1:0] pr,
                                 output logic [COORD_W-1:0] pc);
            longint rb, cb, one;
            rb = longint'(r0) << FRAC_BITS_DEF;
            cb = longint'(c0) << FRAC_BITS_DEF;
            one = longint'(1) << FRAC_BITS_DEF;
            case (e)
                EDGE_T: begin
                    pr = COORD_W'(rb);
                    pc = COORD_W'(cb + crossing(ul, ur, lvl));
                end
                EDGE_B: begin
                    pr = COORD_W'(rb + one);
                    pc = COORD_W'(cb + crossing(ll, lr, lvl));
                end
                EDGE_L: begin
                    pr = COORD_W'(rb + crossing(ul, ll, lvl));
                    pc = COORD_W'(cb);
                end
                default: begin
                    pr = COORD_W'(rb + crossing(ur, lr, lvl));
                    pc = COORD_W'(cb + one);
                end
            endcase
        endfunction

        function void note_pixel(logic [PIX_W-1:0] px);
            int w, h, lvl, ul, ur, ll, lr, nseg;
            logic [PIX_W-1:0] up;
            logic [3:0] sq;
            logic [1:0] ends [4];
            segment_t seg;
            w = eff_width();
            h = eff_height();
            if (col >= w) begin
                col = 0;
                row++;
            end
            if (row >= h) row = 0;
            up = line_buf[col];
            if (row > 0 && col > 0) begin
                lvl = int'($signed(level));
                ul = int'($signed(upleft_px));
                ur = int'($signed(up));
                ll = int'($signed(left_px));
                lr = int'($signed(px));
                sq = {lr > lvl, ll > lvl, ur > lvl, ul > lvl};
                nseg = 1;
                case (sq)
                    4'd1:  ends = '{EDGE_T, EDGE_L, EDGE_T, EDGE_T};
                    4'd2:  ends = '{EDGE_R, EDGE_T, EDGE_T, EDGE_T};
                    4'd3:  ends = '{EDGE_R, EDGE_L, EDGE_T, EDGE_T};
                    4'd4:  ends = '{EDGE_L, EDGE_B, EDGE_T, EDGE_T};
                    4'd5:  ends = '{EDGE_T, EDGE_B, EDGE_T, EDGE_T};
                    4'd7:  ends = '{EDGE_R, EDGE_B, EDGE_T, EDGE_T};
                    4'd8:  ends = '{EDGE_B, EDGE_R, EDGE_T, EDGE_T};
                    4'd10: ends = '{EDGE_B, EDGE_T, EDGE_T, EDGE_T};
                    4'd11: ends = '{EDGE_B, EDGE_L, EDGE_T, EDGE_T};
                    4'd12: ends = '{EDGE_L, EDGE_R, EDGE_T, EDGE_T};
                    4'd13: ends = '{EDGE_T, EDGE_R, EDGE_T, EDGE_T};
                    4'd14: ends = '{EDGE_L, EDGE_T, EDGE_T, EDGE_T};
                    4'd6: begin
                        nseg = 2;
                        if (join_high) ends = '{EDGE_L, EDGE_T, EDGE_R, EDGE_B};
                        else ends = '{EDGE_R, EDGE_T, EDGE_L, EDGE_B};
                    end
                    4'd9: begin
                        nseg = 2;
                        if (join_high) ends = '{EDGE_T, EDGE_R, EDGE_B, EDGE_L};
                        else ends = '{EDGE_T, EDGE_L, EDGE_B, EDGE_R};
                    end
                    default: begin
                        nseg = 0;
                        ends = '{EDGE_T, EDGE_T, EDGE_T, EDGE_T};
                    end
                endcase
                for (int k = 0; k < nseg; k++) begin
                    edge_point(ends[2*k], row - 1, col - 1, ul, ur, ll, lr, lvl,
                               seg.start_row, seg.start_col);
                    edge_point(ends[2*k+1], row - 1, col - 1, ul, ur, ll, lr, lvl,
                               seg.end_row, seg.end_col);
                    seg.last_of_pixel = (k == nseg - 1);
                    expected_segments.push_back(seg);
                end
            end
            upleft_px = up;
            left_px = px;
            line_buf[col] = px;
            col++;
            if (col >= w) begin
                col = 0;
                row++;
                if (row >= h) row = 0;
            end
        endfunction

        function void check_segment(segment_t got);
            segment_t exp_seg;
            if (expected_segments.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("segment with none expected: %h %h %h %h %b", got.start_row,
                             got.start_col, got.end_row, got.end_col, got.last_of_pixel);
                return;
            end
            exp_seg = expected_segments.pop_front();
            if (got.start_row !== exp_seg.start_row || got.start_col !== exp_seg.start_col ||
                got.end_row !== exp_seg.end_row || got.end_col !== exp_seg.end_col ||
                got.last_of_pixel !== exp_seg.last_of_pixel) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("segment mismatch: exp %h %h %h %h %b got %h %h %h %h %b",
                             exp_seg.start_row, exp_seg.start_col, exp_seg.end_row,
                             exp_seg.end_col, exp_seg.last_of_pixel, got.start_row,
                             got.start_col, got.end_row, got.end_col, got.last_of_pixel);
            end
        endfunction

        function int pending();
            return expected_segments.size();
        endfunction
    endclass

    // longest quiet stretch: divider runs of a pixel, stalls, sender gaps, drain pauses
    localparam int WATCHDOG_LIMIT = 3000;
    // settle time after the last segment, covers a pixel that yields nothing
    localparam int SETTLE_CYCLES  = 2 + 4 * (FRAC_BITS_DEF + 3) + 20;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic signed [PIX_W-1:0] s_pixel_value = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [COORD_W-1:0]      m_start_row;
    logic [COORD_W-1:0]      m_start_col;
    logic [COORD_W-1:0]      m_end_row;
    logic [COORD_W-1:0]      m_end_col;
    logic                    m_last_of_pixel;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    contour_scoreboard sb = new();
    int  pixels_sent = 0;
    int  burst_left = 0;
    int  quiet_cycles = 0;
    int  cycle_count = 0;
    int  stall_mode = 0;

    always #5 aclk = ~aclk;

    marching_squares_contour i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pixel_value  (s_pixel_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_start_row    (m_start_row),
        .m_start_col    (m_start_col),
        .m_end_row      (m_end_row),
        .m_end_col      (m_end_col),
        .m_last_of_pixel(m_last_of_pixel),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // monitor: every handshake is seen here, on the values just before the edge
    always @(posedge aclk) begin
        segment_t got;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
            if (s_valid && s_ready) sb.note_pixel(s_pixel_value);
            if (m_valid && m_ready) begin
                got.start_row = m_start_row;
                got.start_col = m_start_col;
                got.end_row = m_end_row;
                got.end_col = m_end_col;
                got.last_of_pixel = m_last_of_pixel;
                sb.check_segment(got);
            end
            // watchdog on cycles with no handshake at all
            if ((cfg_valid && cfg_ready) || (s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // receiver back-pressure: always ready, random, or periodic from the cycle counter
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 300 == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= (cycle_count % 4 == 0);
        endcase
    end

    // one item on the pixel channel, sender may idle between bursts
    task automatic send_pixel(logic [PIX_W-1:0] value);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_pixel_value <= value;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        pixels_sent++;
    endtask

    task automatic stop_pixels();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
    endtask

    // valid stays up between writes, the caller drops it after the last one
    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        forever begin
            @(posedge aclk);
            if (cfg_ready) break;
        end
    endtask

    // idle point: all segments out and the last pixel surely finished
    task automatic drain();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // unused upper bits of the data word are randomised
    task automatic configure(int lvl, bit conn, int w, int h);
        write_cfg(REG_LEVEL, lvl[15:0]);
        write_cfg(REG_CONNECT, {15'($urandom_range(0, 32767)), conn});
        write_cfg(REG_WIDTH, {3'($urandom_range(0, 7)), w[12:0]});
        write_cfg(REG_HEIGHT, {3'($urandom_range(0, 7)), h[12:0]});
        if ($urandom_range(0, 3) == 0)
            write_cfg(CFG_IDX_W'($urandom_range(4, 255)),
                      CFG_DATA_W'($urandom_range(0, 65535)));
        cfg_valid <= 1'b0;
    endtask

    // sample near the level most of the time, so that edges get crossed
    function automatic logic [PIX_W-1:0] pick_pixel(int spread);
        int lvl, v;
        lvl = int'($signed(sb.level));
        case ($urandom_range(0, 9))
            0, 1: v = $urandom_range(0, 65535) - 32768;
            2:    v = lvl;
            3:    v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
            default: v = lvl + $urandom_range(0, 2 * spread) - spread;
        endcase
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    // fill up to the frame origin so that a later width increase reads only written entries
    task automatic finish_frame(bit sparse);
        int n;
        n = sb.pixels_to_frame_end();
        for (int i = 0; i < n; i++)
            send_pixel((sparse && $urandom_range(0, 63) != 0) ? sb.level : pick_pixel(40));
    endtask

    task automatic random_phase(int lvl, bit conn, int w, int h, int count, bit sparse);
        configure(lvl, conn, w, h);
        for (int i = 0; i < count; i++)
            send_pixel((sparse && $urandom_range(0, 63) != 0) ? sb.level : pick_pixel(40));
        finish_frame(sparse);
        stop_pixels();
        drain();
    endtask

    initial begin
        logic [PIX_W-1:0] directed [24];
        int lvl, w, h;
        // 2x2 frames: saddles both ways, full-scale corners, a crossing exactly on a corner,
        // all-high and all-low squares
        directed = '{16'hFFFB, 16'h0007, 16'h0003, 16'hFFFF,
                     16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
                     16'h0064, 16'h0000, 16'h0000, 16'h0000,
                     16'h0001, 16'h0001, 16'h0001, 16'h0001,
                     16'h8000, 16'h8000, 16'h8000, 16'h8000,
                     16'h7FFF, 16'h0000, 16'h8000, 16'hFFFF};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int m = 0; m < 2; m++) begin
            configure(0, 1'(m), 2, 2);
            foreach (directed[i]) send_pixel(directed[i]);
            stop_pixels();
            drain();
        end

        // level extremes
        random_phase(-32768, 0, 5, 4, 40, 0);
        random_phase(32767, 1, 3, 6, 30, 0);
        // out of range sizes clamp: width 0 and height 1, then full width, then full height
        random_phase(0, 1, 0, 1, 8, 0);
        random_phase(7, 0, 13'h1FFF, 2, 0, 1);
        random_phase(-3, 1, 2, 4096, 0, 1);

        // shrinking the frame in mid-row makes the position wrap early
        configure(0, 0, 9, 6);
        for (int i = 0; i < 31; i++) send_pixel(pick_pixel(40));
        stop_pixels();
        drain();
        random_phase(0, 1, 3, 2, 5, 0);

        while (pixels_sent < 1400) begin
            lvl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) - 32768
                                              : $urandom_range(0, 400) - 200;
            w = $urandom_range(2, 14);
            h = $urandom_range(2, 8);
            random_phase(lvl, 1'($urandom_range(0, 1)), w, h, $urandom_range(5, 120), 0);
        end

        drain();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### files.f
rtl/msc_pkg.sv
rtl/msc_ram.sv
rtl/msc_div.sv
rtl/marching_squares_contour.sv
bench/tb.sv
